/* rtl/pidc_pkg.sv */
package pidc_pkg;

	// Field and register widths
	localparam int ERR_W   = 17;
	localparam int GAIN_W  = 20;
	localparam int CLAMP_W = 33;
	localparam int DRIVE_W = 40;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;

	// Register index, taken from paddr[5:3] (8-byte spacing)
	localparam logic [2:0] REG_GAIN_P      = 3'd0;
	localparam logic [2:0] REG_GAIN_I      = 3'd1;
	localparam logic [2:0] REG_GAIN_D      = 3'd2;
	localparam logic [2:0] REG_INTEG_UPPER = 3'd3;
	localparam logic [2:0] REG_INTEG_LOWER = 3'd4;

	// Reset values
	localparam logic [GAIN_W-1:0]         GAIN_P_RST      = 20'd6554;
	localparam logic [GAIN_W-1:0]         GAIN_I_RST      = 20'd655;
	localparam logic [GAIN_W-1:0]         GAIN_D_RST      = 20'd0;
	localparam logic signed [CLAMP_W-1:0] INTEG_UPPER_RST = 33'sh0_FFFF_0000;
	localparam logic signed [CLAMP_W-1:0] INTEG_LOWER_RST = 33'sh1_0001_0000;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
		logic signed [CLAMP_W-1:0] integ_upper;
		logic signed [CLAMP_W-1:0] integ_lower;
	} cfg_t;

endpackage

/* rtl/pid_controller_clamped_integrator_unit.sv */
// PID controller with clamped integrator, 16 fraction bits, one item per cycle while
// the result stream is not stalled. Input register, then result register; both hold
// while the result register is full and m_tready is low.
// The integrator and previous-error registers close their loop on every step.
// Reset (arst_n low) restores default gains and clamps, clears the integrator,
// previous error and first-pass flag, and empties both registers.
module pid_controller_clamped_integrator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,   // [16:0] error_sample, [23:17] zero
	input  logic                         s_tuser,   // [0] restart
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [39:0]                  m_tdata,   // [39:0] drive
	// Configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]  paddr,
	input  logic [pidc_pkg::DATA_W-1:0]  pwdata,
	output logic [pidc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	pidc_pkg::cfg_t cfg;

	logic                                 valid_s1;
	logic signed [pidc_pkg::ERR_W-1:0]    error_s1;
	logic                                 restart_s1;
	logic                                 out_valid_q;
	logic [pidc_pkg::DRIVE_W-1:0]         drive_q;
	logic signed [pidc_pkg::CLAMP_W-1:0]  integ_q;
	logic signed [pidc_pkg::ERR_W-1:0]    prev_q;
	logic                                 started_q;
	logic                                 adv;

	logic signed [pidc_pkg::CLAMP_W-1:0]  integ_cur;
	logic signed [pidc_pkg::ERR_W-1:0]    prev_cur;
	logic                                 started_cur;
	logic signed [37:0]                   prod_i;
	logic signed [37:0]                   prod_p;
	logic signed [17:0]                   diff;
	logic signed [38:0]                   prod_d;
	logic signed [38:0]                   acc;
	logic signed [38:0]                   up_ext;
	logic signed [38:0]                   lo_ext;
	logic signed [38:0]                   clamp_hi;
	logic signed [38:0]                   clamp_lo;
	logic signed [pidc_pkg::CLAMP_W-1:0]  integ_next;
	logic signed [38:0]                   d_term;
	logic signed [pidc_pkg::DRIVE_W-1:0]  sum;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: advance when the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = drive_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			error_s1   <= $signed(s_tdata[pidc_pkg::ERR_W-1:0]);
			restart_s1 <= s_tuser;
		end
	end

	// Restart clears the state ahead of this step
	always_comb begin
		integ_cur   = restart_s1 ? '0 : integ_q;
		prev_cur    = restart_s1 ? '0 : prev_q;
		started_cur = restart_s1 ? 1'b0 : started_q;
	end

	// Integrator: accumulate, clamp upper then lower, hold while gain_i is zero
	always_comb begin
		prod_i   = 38'(error_s1) * $signed({18'd0, cfg.gain_i});
		acc      = 39'(integ_cur) + 39'(prod_i);
		up_ext   = 39'($signed(cfg.integ_upper));
		lo_ext   = 39'($signed(cfg.integ_lower));
		clamp_hi = (acc > up_ext) ? up_ext : acc;
		clamp_lo = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;
		integ_next = (cfg.gain_i != '0) ? clamp_lo[pidc_pkg::CLAMP_W-1:0] : integ_cur;
	end

	// Proportional and derivative terms; the sum stays well inside 40 bits
	always_comb begin
		prod_p = 38'(error_s1) * $signed({18'd0, cfg.gain_p});
		diff   = 18'(error_s1) - 18'(prev_cur);
		prod_d = 39'(diff) * $signed({19'd0, cfg.gain_d});
		d_term = started_cur ? prod_d : '0;
		sum    = 40'(prod_p) + 40'(integ_next) + 40'(d_term);
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			prev_q    <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			integ_q   <= integ_next;
			prev_q    <= error_s1;
			started_q <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= sum;
		end
	end

	// Checks
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> started_q)
		else $error("first-pass flag not set after a step");

	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> prev_q == $past(error_s1))
		else $error("previous error not captured");

	a_restart_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && restart_s1 && cfg.gain_i == '0 |=> integ_q == '0)
		else $error("restart with frozen integrator left it nonzero");

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("result missing after a step");

endmodule

/* rtl/pidc_regs.sv */
module pidc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]    paddr,
	input  logic [pidc_pkg::DATA_W-1:0]    pwdata,
	output logic [pidc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output pidc_pkg::cfg_t                 cfg
);

	pidc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[5:3];
	assign cfg     = cfg_q;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= pidc_pkg::GAIN_P_RST;
			cfg_q.gain_i      <= pidc_pkg::GAIN_I_RST;
			cfg_q.gain_d      <= pidc_pkg::GAIN_D_RST;
			cfg_q.integ_upper <= pidc_pkg::INTEG_UPPER_RST;
			cfg_q.integ_lower <= pidc_pkg::INTEG_LOWER_RST;
		end else if (wr_en) begin
			case (reg_idx)
				pidc_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= pwdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= pwdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= pwdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_INTEG_UPPER: begin
					cfg_q.integ_upper <= $signed(pwdata[pidc_pkg::CLAMP_W-1:0]);
				end
				pidc_pkg::REG_INTEG_LOWER: begin
					cfg_q.integ_lower <= $signed(pwdata[pidc_pkg::CLAMP_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Read back, clamps sign-extended
	always_comb begin
		case (reg_idx)
			pidc_pkg::REG_GAIN_P:      prdata = 64'(cfg_q.gain_p);
			pidc_pkg::REG_GAIN_I:      prdata = 64'(cfg_q.gain_i);
			pidc_pkg::REG_GAIN_D:      prdata = 64'(cfg_q.gain_d);
			pidc_pkg::REG_INTEG_UPPER: prdata = 64'($signed(cfg_q.integ_upper));
			pidc_pkg::REG_INTEG_LOWER: prdata = 64'($signed(cfg_q.integ_lower));
			default:                   prdata = '0;
		endcase
	end

endmodule

/* sim/tb_pid_controller_clamped_integrator_unit.sv */
`timescale 1ns / 100ps

module tb_pid_controller_clamped_integrator_unit;

	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 244;
	localparam int HOLD_LEN   = 300;
	localparam longint CLAMP_MAX = 64'sd4294901760;
	localparam longint DRIVE_HI  = 64'sd549755813887;
	localparam longint DRIVE_LO  = -64'sd549755813888;

	localparam logic [pidc_pkg::GAIN_W-1:0] GAIN_MAX = {pidc_pkg::GAIN_W{1'b1}};

	// Idling schemes
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		bit                                  is_cfg;
		logic [2:0]                          reg_idx;
		longint                              value;
		logic signed [pidc_pkg::ERR_W-1:0]   err;
		bit                                  restart;
		bit                                  typed;
		longint                              drive;
	} dir_row_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [23:0]                   s_tdata  = '0;   // [16:0] error_sample, [23:17] zero
	logic                          s_tuser  = 1'b0; // [0] restart
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [39:0]                   m_tdata;         // [39:0] drive
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [pidc_pkg::ADDR_W-1:0]   paddr    = '0;
	logic [pidc_pkg::DATA_W-1:0]   pwdata   = '0;
	logic [pidc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// Shadow configuration
	logic [pidc_pkg::GAIN_W-1:0]   gain_p_q = pidc_pkg::GAIN_P_RST;
	logic [pidc_pkg::GAIN_W-1:0]   gain_i_q = pidc_pkg::GAIN_I_RST;
	logic [pidc_pkg::GAIN_W-1:0]   gain_d_q = pidc_pkg::GAIN_D_RST;
	longint                        upper_q  = CLAMP_MAX;
	longint                        lower_q  = -CLAMP_MAX;

	// Shadow controller state
	longint              prev_err_q = 0;
	longint              integ_q    = 0;
	bit                  started_q  = 1'b0;

	logic [pidc_pkg::DRIVE_W-1:0]  drive_expected[$];
	idle_mode_t          mode = IDLE_NONE;
	int                  mismatches    = 0;
	int                  hold_requests = 0;
	int                  hold_served   = 0;
	int                  hold_left     = 0;

	pid_controller_clamped_integrator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Advance the shadow controller by one step and return the expected drive
	function automatic logic [pidc_pkg::DRIVE_W-1:0] pid_predict(
		input logic signed [pidc_pkg::ERR_W-1:0] err, input bit restart);
		longint e;
		longint acc;
		longint sum;
		e = err;
		if (restart) begin
			prev_err_q = 0;
			integ_q    = 0;
			started_q  = 1'b0;
		end
		if (gain_i_q != '0) begin
			acc = integ_q + e * longint'(gain_i_q);
			if (acc > upper_q) acc = upper_q;
			if (acc < lower_q) acc = lower_q;
			integ_q = acc;
		end
		sum = e * longint'(gain_p_q) + integ_q;
		if (started_q) sum += (e - prev_err_q) * longint'(gain_d_q);
		started_q  = 1'b1;
		prev_err_q = e;
		if (sum > DRIVE_HI) sum = DRIVE_HI;
		if (sum < DRIVE_LO) sum = DRIVE_LO;
		return sum[pidc_pkg::DRIVE_W-1:0];
	endfunction

	function automatic logic [pidc_pkg::GAIN_W-1:0] rand_gain();
		if ($urandom_range(0, 3) == 0) return pidc_pkg::GAIN_W'($urandom_range(0, 255));
		return pidc_pkg::GAIN_W'($urandom_range(0, 20'hFFFFF));
	endfunction

	function automatic longint rand_clamp();
		longint v;
		if ($urandom_range(0, 1)) v = longint'($urandom_range(0, 32'hFFFF0000));
		else v = longint'($urandom_range(0, 32'h0040_0000));
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	function automatic logic signed [pidc_pkg::ERR_W-1:0] rand_error();
		case ($urandom_range(0, 3))
			0: return pidc_pkg::ERR_W'($urandom_range(0, 127)) - 17'sd64;
			1: begin
				case ($urandom_range(0, 4))
					0: return 17'sh0FFFF;
					1: return 17'sh10000;
					2: return 17'sd1;
					3: return -17'sd1;
					default: return 17'sd0;
				endcase
			end
			default: return pidc_pkg::ERR_W'($urandom());
		endcase
	endfunction

	// Hold off the input, then wait for every expected drive to arrive
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (drive_expected.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// APB write of one register; the block must be idle
	task automatic write_register(input logic [2:0] idx, input longint value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			pidc_pkg::REG_GAIN_P:      gain_p_q = value[pidc_pkg::GAIN_W-1:0];
			pidc_pkg::REG_GAIN_I:      gain_i_q = value[pidc_pkg::GAIN_W-1:0];
			pidc_pkg::REG_GAIN_D:      gain_d_q = value[pidc_pkg::GAIN_W-1:0];
			pidc_pkg::REG_INTEG_UPPER: upper_q  = $signed(value[pidc_pkg::CLAMP_W-1:0]);
			pidc_pkg::REG_INTEG_LOWER: lower_q  = $signed(value[pidc_pkg::CLAMP_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one error item, with random idle cycles ahead of it
	task automatic send_error(input logic signed [pidc_pkg::ERR_W-1:0] err,
		input bit restart, input bit typed, input longint typed_drive);
		logic [pidc_pkg::DRIVE_W-1:0] predicted;
		int idle_pct;
		idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 23 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, err};
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = pid_predict(err, restart);
		drive_expected.push_back(typed ? typed_drive[pidc_pkg::DRIVE_W-1:0] : predicted);
		@(negedge clk);
	endtask

	// Drive the result ready: random stalls per mode, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			m_tready    <= 1'b0;
			hold_left   <= HOLD_LEN;
			hold_served <= hold_served + 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >=
				((mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 23 : 0));
		end
	end

	// Compare each accepted drive with the oldest expectation
	always @(posedge clk) begin
		logic [pidc_pkg::DRIVE_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_expected.size() == 0) begin
				$error("drive: expected none, actual %0d", $signed(m_tdata));
				mismatches++;
			end else begin
				want = drive_expected.pop_front();
				if (m_tdata !== want) begin
					$error("drive: expected %0d, actual %0d", $signed(want), $signed(m_tdata));
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		longint up;
		longint lo;
		longint tmp;

		// Reset defaults, first pass, restart and error extremes
		rows.push_back('{0, 0, 0, 17'sd0, 0, 1, 0});
		rows.push_back('{0, 0, 0, 17'sd1, 0, 1, 7209});
		rows.push_back('{0, 0, 0, -17'sd1, 1, 1, -7209});
		rows.push_back('{0, 0, 0, 17'sh0FFFF, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh10000, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sd0, 1, 1, 0});
		// Largest derivative gain and swing, then a first pass after restart
		rows.push_back('{1, pidc_pkg::REG_GAIN_D, longint'(GAIN_MAX), 17'sd0, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh0FFFF, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh10000, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sd5, 1, 0, 0});
		// Zero integral gain holds the integrator
		rows.push_back('{1, pidc_pkg::REG_GAIN_I, 0, 17'sd0, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh0FFFF, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh10000, 0, 0, 0});
		// Narrow clamps hit from both sides
		rows.push_back('{1, pidc_pkg::REG_GAIN_I, longint'(GAIN_MAX), 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_GAIN_P, 0, 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_GAIN_D, 0, 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_INTEG_UPPER, 65536, 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_INTEG_LOWER, -65536, 17'sd0, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sd3, 1, 1, 65536});
		rows.push_back('{0, 0, 0, -17'sd3, 0, 1, -65536});
		// Crossed clamps end at the lower bound
		rows.push_back('{1, pidc_pkg::REG_INTEG_UPPER, -131072, 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_INTEG_LOWER, 131072, 17'sd0, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sd0, 1, 1, 131072});
		rows.push_back('{0, 0, 0, 17'sd1000, 0, 1, 131072});
		// All gains at maximum, widest clamps
		rows.push_back('{1, pidc_pkg::REG_GAIN_P, longint'(GAIN_MAX), 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_GAIN_D, longint'(GAIN_MAX), 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_INTEG_UPPER, CLAMP_MAX, 17'sd0, 0, 0, 0});
		rows.push_back('{1, pidc_pkg::REG_INTEG_LOWER, -CLAMP_MAX, 17'sd0, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh0FFFF, 1, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh10000, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh0FFFF, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sh10000, 0, 0, 0});
		rows.push_back('{0, 0, 0, 17'sd0, 1, 0, 0});

		// Hold reset, then release it on a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain_results();
				write_register(rows[i].reg_idx, rows[i].value);
			end else begin
				send_error(rows[i].err, rows[i].restart, rows[i].typed, rows[i].drive);
			end
		end

		// Random phases, each with its own setting and idling scheme
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			mode = idle_mode_t'(p % 4);
			up = rand_clamp();
			lo = rand_clamp();
			if ((p == 3) == (up > lo)) begin
				tmp = up;
				up  = lo;
				lo  = tmp;
			end
			case (p)
				0: begin
					write_register(pidc_pkg::REG_GAIN_P, longint'(GAIN_MAX));
					write_register(pidc_pkg::REG_GAIN_I, longint'(GAIN_MAX));
					write_register(pidc_pkg::REG_GAIN_D, longint'(GAIN_MAX));
					up = CLAMP_MAX;
					lo = -CLAMP_MAX;
				end
				1: begin
					write_register(pidc_pkg::REG_GAIN_P, 0);
					write_register(pidc_pkg::REG_GAIN_I, 0);
					write_register(pidc_pkg::REG_GAIN_D, 0);
				end
				2: begin
					write_register(pidc_pkg::REG_GAIN_P, longint'(rand_gain()));
					write_register(pidc_pkg::REG_GAIN_I, 0);
					write_register(pidc_pkg::REG_GAIN_D, longint'(rand_gain()));
				end
				default: begin
					write_register(pidc_pkg::REG_GAIN_P, longint'(rand_gain()));
					write_register(pidc_pkg::REG_GAIN_I, longint'(rand_gain()));
					write_register(pidc_pkg::REG_GAIN_D, longint'(rand_gain()));
				end
			endcase
			write_register(pidc_pkg::REG_INTEG_UPPER, up);
			write_register(pidc_pkg::REG_INTEG_LOWER, lo);

			for (int n = 0; n < PHASE_LEN; n++) begin
				// Long receiver hold-off while items keep coming
				if (p == 4 && n == 60) hold_requests++;
				// Sender pause until the pipeline is empty
				if (p == 5 && n == 120) drain_results();
				send_error(rand_error(), ($urandom_range(0, 15) == 0), 1'b0, 0);
			end
		end

		// Wait out the remaining results
		s_tvalid <= 1'b0;
		while (drive_expected.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && drive_expected.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
